[sv/pgw_pkg.sv]
// Page walker package: widths, frame masks, codes and shared types.
package pgw_pkg;

  localparam int PHYS_ADDR_BITS = 36;
  localparam int ADDR_W         = 64;
  localparam int VA_W           = 48;
  localparam int PA_W           = 52;
  localparam int IDX_W          = 9;

  localparam int PRESENT_BIT = 0;
  localparam int LARGE_BIT   = 7;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_ENTRY   = 1'b1;
  localparam logic RES_READ     = 1'b0;
  localparam logic RES_DONE     = 1'b1;

  localparam logic [ADDR_W-1:0] BASE_MASK       = ~64'hF;
  localparam logic [ADDR_W-1:0] PHYS_LIMIT_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
  localparam logic [ADDR_W-1:0] FRAME_4K_MASK   = PHYS_LIMIT_MASK & ~64'hFFF;
  localparam logic [ADDR_W-1:0] FRAME_2M_MASK   = PHYS_LIMIT_MASK & ~64'h1F_FFFF;
  localparam logic [ADDR_W-1:0] FRAME_1G_MASK   = 64'h000F_FFFF_C000_0000;

  typedef enum logic [2:0] {
    LVL_IDLE = 3'd0,
    LVL_PML4 = 3'd1,
    LVL_PDPT = 3'd2,
    LVL_PD   = 3'd3,
    LVL_PT   = 3'd4
  } level_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] table_base;
    logic [VA_W-1:0]   virtual_address;
    logic [ADDR_W-1:0] entry_data;
  } item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] read_address;
    logic [PA_W-1:0]   phys_addr;
  } result_t;

  typedef struct packed {
    level_t          level;
    logic [VA_W-1:0] va;
  } walk_state_t;

endpackage

[sv/pgw_in_if.sv]
// Input channel: translation requests and returned table entries.
interface pgw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [pgw_pkg::ADDR_W-1:0]  table_base;
  logic [pgw_pkg::VA_W-1:0]    virtual_address;
  logic [pgw_pkg::ADDR_W-1:0]  entry_data;

  modport source (output valid, kind, table_base, virtual_address, entry_data,
                  input ready);
  modport sink   (input valid, kind, table_base, virtual_address, entry_data,
                  output ready);
endinterface

[sv/pgw_out_if.sv]
// Result channel: memory read requests and finished translations.
interface pgw_out_if;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [pgw_pkg::ADDR_W-1:0] read_address;
  logic [pgw_pkg::PA_W-1:0]   phys_addr;

  modport source (output valid, result_kind, read_address, phys_addr,
                  input ready);
  modport sink   (input valid, result_kind, read_address, phys_addr,
                  output ready);
endinterface

[sv/pgw_step.sv]
// One walk step: next walk state and result from the current state and one item.
module pgw_step (
  input  pgw_pkg::item_t       item,
  input  pgw_pkg::walk_state_t state,
  output pgw_pkg::walk_state_t state_nxt,
  output pgw_pkg::result_t     res,
  output logic                 res_valid
);

  logic [pgw_pkg::ADDR_W-1:0] e;
  logic [pgw_pkg::ADDR_W-1:0] frame_4k;
  logic [pgw_pkg::ADDR_W-1:0] pa_1g;
  logic [pgw_pkg::ADDR_W-1:0] pa_2m;
  logic [pgw_pkg::ADDR_W-1:0] pa_4k;
  logic [pgw_pkg::ADDR_W-1:0] off_pml4;
  logic [pgw_pkg::ADDR_W-1:0] off_pdpt;
  logic [pgw_pkg::ADDR_W-1:0] off_pd;
  logic [pgw_pkg::ADDR_W-1:0] off_pt;
  logic                       present;
  logic                       big_page;

  assign e        = item.entry_data;
  assign present  = e[pgw_pkg::PRESENT_BIT];
  assign big_page = e[pgw_pkg::LARGE_BIT];
  assign frame_4k = e & pgw_pkg::FRAME_4K_MASK;

  // entry index times 8, never reaches bit 12 so an OR with the frame adds
  assign off_pml4 = {52'd0, item.virtual_address[47:39], 3'b000};
  assign off_pdpt = {52'd0, state.va[38:30], 3'b000};
  assign off_pd   = {52'd0, state.va[29:21], 3'b000};
  assign off_pt   = {52'd0, state.va[20:12], 3'b000};

  assign pa_1g = (e & pgw_pkg::FRAME_1G_MASK) | {34'd0, state.va[29:0]};
  assign pa_2m = (e & pgw_pkg::FRAME_2M_MASK) | {43'd0, state.va[20:0]};
  assign pa_4k = frame_4k | {52'd0, state.va[11:0]};

  always_comb begin
    state_nxt = state;
    res       = '0;
    res_valid = 1'b0;
    if (item.kind == pgw_pkg::KIND_REQUEST) begin
      state_nxt.level  = pgw_pkg::LVL_PML4;
      state_nxt.va     = item.virtual_address;
      res_valid        = 1'b1;
      res.result_kind  = pgw_pkg::RES_READ;
      res.read_address = (item.table_base & pgw_pkg::BASE_MASK) + off_pml4;
    end else begin
      case (state.level)
        pgw_pkg::LVL_IDLE: begin
          res_valid = 1'b0;
        end
        pgw_pkg::LVL_PML4: begin
          res_valid = 1'b1;
          if (!present) begin
            state_nxt.level = pgw_pkg::LVL_IDLE;
            res.result_kind = pgw_pkg::RES_DONE;
          end else begin
            state_nxt.level  = pgw_pkg::LVL_PDPT;
            res.result_kind  = pgw_pkg::RES_READ;
            res.read_address = frame_4k | off_pdpt;
          end
        end
        pgw_pkg::LVL_PDPT: begin
          res_valid = 1'b1;
          if (!present) begin
            state_nxt.level = pgw_pkg::LVL_IDLE;
            res.result_kind = pgw_pkg::RES_DONE;
          end else if (big_page) begin
            state_nxt.level = pgw_pkg::LVL_IDLE;
            res.result_kind = pgw_pkg::RES_DONE;
            res.phys_addr   = pa_1g[pgw_pkg::PA_W-1:0];
          end else begin
            state_nxt.level  = pgw_pkg::LVL_PD;
            res.result_kind  = pgw_pkg::RES_READ;
            res.read_address = frame_4k | off_pd;
          end
        end
        pgw_pkg::LVL_PD: begin
          res_valid = 1'b1;
          if (!present) begin
            state_nxt.level = pgw_pkg::LVL_IDLE;
            res.result_kind = pgw_pkg::RES_DONE;
          end else if (big_page) begin
            state_nxt.level = pgw_pkg::LVL_IDLE;
            res.result_kind = pgw_pkg::RES_DONE;
            res.phys_addr   = pa_2m[pgw_pkg::PA_W-1:0];
          end else begin
            state_nxt.level  = pgw_pkg::LVL_PT;
            res.result_kind  = pgw_pkg::RES_READ;
            res.read_address = frame_4k | off_pt;
          end
        end
        pgw_pkg::LVL_PT: begin
          // no present check at the last level; an empty frame fails
          res_valid       = 1'b1;
          state_nxt.level = pgw_pkg::LVL_IDLE;
          res.result_kind = pgw_pkg::RES_DONE;
          if (frame_4k != '0) begin
            res.phys_addr = pa_4k[pgw_pkg::PA_W-1:0];
          end
        end
        default: begin
          state_nxt.level = pgw_pkg::LVL_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/four_level_page_walker_top.sv]
// Four-level page table walker: input register, walk step logic, result register.
// Each item passes the input register, then its result is held in the result register.
// Throughput: one item per cycle; a stalled result holds one more item in the input register.
// Data items that arrive with no walk open are dropped without a result.
// Reset (rst_n low, synchronous) empties both registers and leaves the walker idle.
module four_level_page_walker_top (
  input logic        clk,
  input logic        rst_n,
  pgw_in_if.sink     in_ch,
  pgw_out_if.source  out_ch
);

  logic                 s1_valid_r;
  pgw_pkg::item_t       s1_item_r;
  pgw_pkg::walk_state_t walk_r;
  pgw_pkg::walk_state_t walk_nxt;
  logic                 out_valid_r;
  pgw_pkg::result_t     out_res_r;
  pgw_pkg::result_t     step_res;
  logic                 step_res_valid;
  logic                 out_free;
  logic                 s1_fire;
  logic                 in_fire;
  pgw_pkg::item_t       in_item;

  assign in_item.kind            = in_ch.kind;
  assign in_item.table_base      = in_ch.table_base;
  assign in_item.virtual_address = in_ch.virtual_address;
  assign in_item.entry_data      = in_ch.entry_data;

  pgw_step u_step (
    .item      (s1_item_r),
    .state     (walk_r),
    .state_nxt (walk_nxt),
    .res       (step_res),
    .res_valid (step_res_valid)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!step_res_valid || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      walk_r.level <= pgw_pkg::LVL_IDLE;
      walk_r.va    <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_fire) begin
        walk_r <= walk_nxt;
      end
      if (s1_fire && step_res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_fire && step_res_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_res_r.result_kind;
  assign out_ch.read_address = out_res_r.read_address;
  assign out_ch.phys_addr    = out_res_r.phys_addr;

endmodule

[sv/pgw_chk.sv]
// Port checker for the page walker, bound to the top level.
module pgw_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       result_kind,
  input logic [pgw_pkg::ADDR_W-1:0] read_address,
  input logic [pgw_pkg::PA_W-1:0]   phys_addr
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind)
      && $stable(read_address) && $stable(phys_addr))
    else $error("result changed while stalled");

  a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (result_kind == pgw_pkg::RES_READ && phys_addr == '0)
      || (result_kind == pgw_pkg::RES_DONE && read_address == '0))
    else $error("unused result field not zero");

  a_read_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == pgw_pkg::RES_READ |-> read_address[2:0] == 3'b000)
    else $error("entry read not 8-byte aligned");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind four_level_page_walker_top pgw_chk u_pgw_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_kind  (out_ch.result_kind),
  .read_address (out_ch.read_address),
  .phys_addr    (out_ch.phys_addr)
);
